>>> src/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// shared types and calendar constants for the date-time decrement unit
// ----------------------------------------------------------------------------
package ctd_pkg;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } date_time_t;

    typedef struct packed {
        date_time_t dt;
        logic       underflow;
    } ctd_res_t;

    localparam logic [5:0]  SecsPerMin  = 6'd60;
    localparam logic [5:0]  LastMinute  = 6'd59;
    localparam logic [4:0]  LastHour    = 5'd23;
    localparam logic [3:0]  MonthJan    = 4'd1;
    localparam logic [3:0]  MonthFeb    = 4'd2;
    localparam logic [3:0]  MonthDec    = 4'd12;
    localparam logic [4:0]  DaysLong    = 5'd31;
    localparam logic [4:0]  DaysFebLeap = 5'd29;

    // floor(y / 25) = (y * Recip25) >> Recip25Shift, exact for 14-bit y
    localparam logic [14:0] Recip25      = 15'd20972;
    localparam int          Recip25Shift = 19;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        begin
            unique case (month)
                4'd2:                      d = leap ? DaysFebLeap : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
                default:                   d = DaysLong;
            endcase
            return d;
        end
    endfunction

endpackage

>>> src/ctd_borrow.sv
// ----------------------------------------------------------------------------
// ctd_borrow
// borrow chain from second through year, with the leap-year test
// ----------------------------------------------------------------------------
module ctd_borrow (
    input  ctd_pkg::date_time_t dt,
    input  logic [7:0]          seconds_back,
    output ctd_pkg::ctd_res_t   res
);
    import ctd_pkg::*;

    logic [5:0]  back_sat;
    logic        no_borrow;
    logic [6:0]  sec_wrap;
    logic        hour_borrow;
    logic        day_borrow;
    logic [5:0]  minute_dec;
    logic [4:0]  hour_dec;
    logic [4:0]  day_mid;
    logic        month_borrow;
    logic [3:0]  month_new;
    logic [13:0] year_new;
    logic        under;
    logic [28:0] recip_prod;
    logic [9:0]  quot25;
    logic [13:0] quot25_x25;
    logic        rem25_zero;
    logic        leap;

    assign back_sat  = (seconds_back > {2'b00, SecsPerMin}) ? SecsPerMin : seconds_back[5:0];
    assign no_borrow = dt.second >= back_sat;
    assign sec_wrap  = {1'b0, dt.second} + {1'b0, SecsPerMin} - {1'b0, back_sat};

    assign hour_borrow = dt.minute == '0;
    assign minute_dec  = hour_borrow ? LastMinute : dt.minute - 6'd1;
    assign day_borrow  = hour_borrow && (dt.hour == '0);
    assign hour_dec    = !hour_borrow ? dt.hour :
                         (dt.hour == '0) ? LastHour : dt.hour - 5'd1;

    always_comb
    begin
        if (!day_borrow)
        begin
            day_mid = dt.day;
        end
        else if (dt.day <= 5'd1)
        begin
            day_mid = '0;
        end
        else
        begin
            day_mid = dt.day - 5'd1;
        end
    end

    assign month_borrow = day_mid == '0;

    always_comb
    begin
        month_new = dt.month;
        year_new  = dt.year;
        under     = 1'b0;
        priority if (dt.month <= MonthJan)
        begin
            month_new = MonthDec;
            if (dt.year == '0)
            begin
                under = 1'b1;
            end
            else
            begin
                year_new = dt.year - 14'd1;
            end
        end
        else if (dt.month > MonthDec)
        begin
            month_new = MonthDec;
        end
        else
        begin
            month_new = dt.month - 4'd1;
        end
    end

    // february only follows march, so the leap test uses the unchanged year
    assign recip_prod = 29'(dt.year) * 29'(Recip25);
    assign quot25     = recip_prod[Recip25Shift +: 10];
    assign quot25_x25 = 14'({quot25, 4'b0000}) + 14'({quot25, 3'b000}) + 14'(quot25);
    assign rem25_zero = quot25_x25 == dt.year;
    assign leap       = ((dt.year[1:0] == 2'b00) && !rem25_zero) ||
                        ((dt.year[3:0] == 4'b0000) && rem25_zero);

    always_comb
    begin
        res.dt        = dt;
        res.underflow = 1'b0;
        if (no_borrow)
        begin
            res.dt.second = dt.second - back_sat;
        end
        else
        begin
            res.dt.second = sec_wrap[5:0];
            res.dt.minute = minute_dec;
            res.dt.hour   = hour_dec;
            res.dt.day    = day_mid;
            if (month_borrow)
            begin
                res.dt.month  = month_new;
                res.dt.year   = year_new;
                res.underflow = under;
                res.dt.day    = month_days(month_new, leap);
            end
        end
    end

endmodule

>>> src/calendar_time_decrement_unit.sv
// ----------------------------------------------------------------------------
// calendar_time_decrement_unit
// subtracts up to 60 seconds from a gregorian date-time
//
// input channel: in_valid / in_stall with year, month, day, hour, minute,
// second and seconds_back; output channel: out_valid / out_stall with the
// earlier date-time and year_underflow. an item moves on each edge where
// valid is high and stall is low.
// the path is an input register, then the borrow chain and leap
// test, then the result register. one item per cycle is sustained when the
// receiver does not stall; the path between the two registers is the month
// borrow plus one 14 x 15 bit multiply for the divide-by-25 leap test.
// when the receiver stalls, the result register holds and the input register
// still takes one more item; in_stall rises only when both are full.
// reset clears both valid flags; no item is lost or repeated.
// ----------------------------------------------------------------------------
module calendar_time_decrement_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [7:0]  seconds_back,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] out_year,
    output logic [3:0]  out_month,
    output logic [4:0]  out_day,
    output logic [4:0]  out_hour,
    output logic [5:0]  out_minute,
    output logic [5:0]  out_second,
    output logic        year_underflow
);
    import ctd_pkg::*;

    logic       s1_valid_reg;
    date_time_t s1_dt_reg;
    logic [7:0] s1_back_reg;
    logic       res_valid_reg;
    ctd_res_t   res_reg;
    ctd_res_t   res_next;
    logic       res_en;
    logic       s1_en;

    assign res_en   = !res_valid_reg || !out_stall;
    assign s1_en    = !s1_valid_reg || res_en;
    assign in_stall = !s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= in_valid;
            end
            if (res_en)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            s1_dt_reg   <= '{year: year, month: month, day: day, hour: hour,
                             minute: minute, second: second};
            s1_back_reg <= seconds_back;
        end
        if (res_en && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    ctd_borrow u_borrow (
        .dt           (s1_dt_reg),
        .seconds_back (s1_back_reg),
        .res          (res_next)
    );

    assign out_valid      = res_valid_reg;
    assign out_year       = res_reg.dt.year;
    assign out_month      = res_reg.dt.month;
    assign out_day        = res_reg.dt.day;
    assign out_hour       = res_reg.dt.hour;
    assign out_minute     = res_reg.dt.minute;
    assign out_second     = res_reg.dt.second;
    assign year_underflow = res_reg.underflow;

    // a year underflow always lands on the last day of december, year 0
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.underflow |->
            res_reg.dt.year == '0 && res_reg.dt.month == MonthDec &&
            res_reg.dt.day == DaysLong)
        else $error("underflow result not at december 31 of year 0");

    // a waiting input item is held while the result register is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && out_stall |=>
            s1_valid_reg && $stable(s1_dt_reg) && $stable(s1_back_reg))
        else $error("input register lost an item while blocked");

    // a taken result with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !out_stall && !s1_valid_reg |=> !res_valid_reg)
        else $error("result repeated after it was taken");

    // an item in the input register reaches the output on the next free edge
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && (!res_valid_reg || !out_stall) |=> res_valid_reg)
        else $error("item dropped between stages");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks calendar_time_decrement_unit against its own date-time predictor
//
// a queue of start times, directed corner cases first and then random ones
// aimed at month, leap-year and underflow borrows, feeds a falling-edge
// driver. each accepted item is predicted into a queue of expected earlier
// date-times, which a rising-edge monitor pops and compares field by field.
// both sides idle at random, with quiet stretches and occasional long gaps.
// ----------------------------------------------------------------------------
module tb_top;
    import ctd_pkg::*;

    typedef struct packed {
        date_time_t  t;
        logic [7:0]  back;
    } start_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [13:0] year = '0;
    logic [3:0]  month = '0;
    logic [4:0]  day = '0;
    logic [4:0]  hour = '0;
    logic [5:0]  minute = '0;
    logic [5:0]  second = '0;
    logic [7:0]  seconds_back = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic        year_underflow;

    start_item_t start_q[$];
    ctd_res_t    earlier_q[$];
    start_item_t nxt;
    ctd_res_t    want;
    logic        in_took = 1'b0;
    int          errors = 0;
    int          tx_gap = 0;
    int          tx_calm = 0;
    int          rx_calm = 0;
    int          hold_left = 0;
    int          free_left = 0;

    calendar_time_decrement_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .year           (year),
        .month          (month),
        .day            (day),
        .hour           (hour),
        .minute         (minute),
        .second         (second),
        .seconds_back   (seconds_back),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_year       (out_year),
        .out_month      (out_month),
        .out_day        (out_day),
        .out_hour       (out_hour),
        .out_minute     (out_minute),
        .out_second     (out_second),
        .year_underflow (year_underflow)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic [13:0] y);
        logic is_leap;
        begin
            is_leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            case (m)
                MonthFeb:                days_in = is_leap ? DaysFebLeap : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11: days_in = 5'd30;
                default:                 days_in = DaysLong;
            endcase
        end
    endfunction

    function automatic ctd_res_t rewind_clock(input date_time_t t, input logic [7:0] back);
        ctd_res_t   r;
        logic [5:0] n;
        logic       hour_borrow;
        logic       day_borrow;
        begin
            r.dt = t;
            r.underflow = 1'b0;
            n = (back > 8'd60) ? SecsPerMin : back[5:0];
            if (t.second >= n)
            begin
                r.dt.second = t.second - n;
            end
            else
            begin
                r.dt.second = t.second + (SecsPerMin - n);
                hour_borrow = (t.minute == 6'd0);
                r.dt.minute = hour_borrow ? LastMinute : t.minute - 6'd1;
                day_borrow = 1'b0;
                if (hour_borrow)
                begin
                    if (t.hour == 5'd0)
                    begin
                        r.dt.hour = LastHour;
                        day_borrow = 1'b1;
                    end
                    else
                    begin
                        r.dt.hour = t.hour - 5'd1;
                    end
                end
                if (day_borrow)
                    r.dt.day = (t.day <= 5'd1) ? 5'd0 : t.day - 5'd1;
                if (r.dt.day == 5'd0)
                begin
                    if (t.month <= MonthJan)
                    begin
                        r.dt.month = MonthDec;
                        if (t.year == 14'd0)
                            r.underflow = 1'b1;
                        else
                            r.dt.year = t.year - 14'd1;
                    end
                    else if (t.month > MonthDec)
                    begin
                        r.dt.month = MonthDec;
                    end
                    else
                    begin
                        r.dt.month = t.month - 4'd1;
                    end
                    r.dt.day = days_in(r.dt.month, r.dt.year);
                end
            end
            return r;
        end
    endfunction

    // mostly short gaps, a few long ones, and now and then a quiet stretch
    function automatic int idle_len(inout int calm);
        int r;
        begin
            if (calm > 0)
            begin
                calm--;
                return 0;
            end
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                calm = $urandom_range(20, 80);
                return 0;
            end
            if (r < 55)
                return 0;
            if (r < 85)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 12);
            return $urandom_range(20, 50);
        end
    endfunction

    task automatic add_start(input int y, input int mo, input int d, input int h,
                             input int mi, input int s, input int b);
        start_item_t it;
        begin
            it.t.year   = 14'(y);
            it.t.month  = 4'(mo);
            it.t.day    = 5'(d);
            it.t.hour   = 5'(h);
            it.t.minute = 6'(mi);
            it.t.second = 6'(s);
            it.back     = 8'(b);
            start_q.push_back(it);
        end
    endtask

    // mostly well-formed times biased toward borrow boundaries, plus raw noise
    task automatic add_random_start();
        start_item_t it;
        int          k;
        begin
            k = $urandom_range(0, 99);
            if (k < 12)
            begin
                it.t.year   = 14'($urandom);
                it.t.month  = 4'($urandom);
                it.t.day    = 5'($urandom);
                it.t.hour   = 5'($urandom);
                it.t.minute = 6'($urandom);
                it.t.second = 6'($urandom);
                it.back     = 8'($urandom);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       it.t.year = 14'($urandom_range(0, 3));
                    1:       it.t.year = 14'(100 * $urandom_range(0, 99));
                    2:       it.t.year = 14'(4 * $urandom_range(0, 2499));
                    default: it.t.year = 14'($urandom_range(0, 9999));
                endcase
                it.t.month  = (k < 20) ? 4'($urandom_range(0, 15))
                            : 4'($urandom_range(1, 12));
                it.t.day    = $urandom_range(0, 1) ? 5'd1
                            : 5'($urandom_range(1, days_in(it.t.month, it.t.year)));
                it.t.hour   = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(0, 23));
                it.t.minute = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(0, 59));
                it.t.second = $urandom_range(0, 1) ? 6'($urandom_range(0, 3))
                            : 6'($urandom_range(0, 59));
                k = $urandom_range(0, 99);
                if (k < 75)
                    it.back = 8'($urandom_range(0, 60));
                else if (k < 90)
                    it.back = 8'($urandom_range(55, 60));
                else
                    it.back = 8'($urandom_range(61, 255));
            end
            start_q.push_back(it);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        begin
            if (act_v !== exp_v)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
                errors++;
            end
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_took)
        begin
            // stalled item holds
        end
        else if (tx_gap > 0)
        begin
            in_valid <= 1'b0;
            tx_gap--;
        end
        else if (start_q.size() > 0)
        begin
            nxt = start_q.pop_front();
            year         <= nxt.t.year;
            month        <= nxt.t.month;
            day          <= nxt.t.day;
            hour         <= nxt.t.hour;
            minute       <= nxt.t.minute;
            second       <= nxt.t.second;
            seconds_back <= nxt.back;
            in_valid     <= 1'b1;
            tx_gap = idle_len(tx_calm);
        end
        else
        begin
            in_valid <= 1'b0;
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_left == 0 && free_left == 0)
            begin
                hold_left = idle_len(rx_calm);
                free_left = $urandom_range(1, 6);
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                free_left--;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        in_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            earlier_q.push_back(rewind_clock(
                date_time_t'({year, month, day, hour, minute, second}), seconds_back));
        if (rst_n && out_valid && !out_stall)
        begin
            if (earlier_q.size() == 0)
            begin
                $display("%0t: unexpected item, expected none got %0d-%0d-%0d %0d:%0d:%0d",
                         $time, out_year, out_month, out_day, out_hour, out_minute,
                         out_second);
                errors++;
            end
            else
            begin
                want = earlier_q.pop_front();
                check_field("out_year", 16'(want.dt.year), 16'(out_year));
                check_field("out_month", 16'(want.dt.month), 16'(out_month));
                check_field("out_day", 16'(want.dt.day), 16'(out_day));
                check_field("out_hour", 16'(want.dt.hour), 16'(out_hour));
                check_field("out_minute", 16'(want.dt.minute), 16'(out_minute));
                check_field("out_second", 16'(want.dt.second), 16'(out_second));
                check_field("year_underflow", 16'(want.underflow), 16'(year_underflow));
            end
        end
    end

    initial
    begin
        // leap rules across february
        add_start(2024, 3, 1, 0, 0, 0, 1);
        add_start(2023, 3, 1, 0, 0, 0, 1);
        add_start(1900, 3, 1, 0, 0, 0, 1);
        add_start(2000, 3, 1, 0, 0, 0, 1);
        // year underflow out of january
        add_start(0, 1, 1, 0, 0, 0, 5);
        // whole minute back across the new year
        add_start(2024, 1, 1, 0, 0, 0, 60);
        // no second borrow, zero count, saturated counts
        add_start(2023, 6, 15, 12, 30, 59, 0);
        add_start(2023, 6, 15, 12, 30, 0, 0);
        add_start(2023, 6, 15, 12, 30, 30, 255);
        add_start(2023, 6, 15, 12, 30, 59, 61);
        // out of range fields passed through
        add_start(16383, 15, 31, 31, 63, 63, 3);
        // minute and hour above range
        add_start(2023, 6, 15, 12, 63, 0, 1);
        add_start(2023, 6, 15, 31, 0, 0, 1);
        // day zero, with and without a day borrow
        add_start(2023, 5, 0, 10, 10, 0, 1);
        add_start(2023, 5, 0, 0, 0, 0, 1);
        // month zero and months above twelve
        add_start(5, 0, 1, 0, 0, 0, 1);
        add_start(0, 0, 1, 0, 0, 0, 1);
        add_start(2023, 13, 1, 0, 0, 0, 1);
        add_start(2023, 15, 0, 5, 5, 5, 10);
        // field extremes and month lengths
        add_start(9999, 12, 31, 23, 59, 59, 255);
        add_start(16383, 1, 1, 0, 0, 0, 1);
        add_start(2023, 4, 1, 0, 0, 0, 60);
        add_start(2023, 5, 1, 0, 0, 0, 30);
        add_start(2023, 12, 1, 0, 0, 0, 1);
        add_start(0, 0, 0, 0, 0, 0, 0);
        repeat (1150)
            add_random_start();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (start_q.size() > 0 || in_valid)
            @(posedge clk);
        while (earlier_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #1500000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
